@@ rtl/core/prpb_pkg.sv @@
// shared constants and types for the pixel ray to base-frame locator
package prpb_pkg;

  // fixed point format and result width
  localparam int FRAC_BITS = 16;
  localparam int RES_W     = 32;
  localparam int QUO_BITS  = RES_W - 1;
  localparam int DIV_LAT   = QUO_BITS + 3;

  // field widths
  localparam int FOCAL_W    = 31;
  localparam int NORM_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COEF_DEPTH = 12;
  localparam int COEF_IDX_W = 4;
  localparam int COEF_COLS  = 4;
  localparam int AXES       = 3;
  localparam int Z_W        = 19;

  // product and truncation widths
  localparam int PROD_W    = 2 * RES_W;
  localparam int TRUNC_W   = PROD_W - FRAC_BITS;
  localparam int SAT_IN_W  = TRUNC_W + 4;
  localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

  // saturation limits
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // reset values of the camera registers
  localparam int FOCAL_RST = 1000 << FRAC_BITS;
  localparam int CX_RST    = 640 << FRAC_BITS;
  localparam int CY_RST    = 480 << FRAC_BITS;
  localparam int NZ_RST    = 1 << FRAC_BITS;

  // base frame offsets in mm
  localparam int OFFSET_X = 40 << FRAC_BITS;
  localparam int OFFSET_Z = 65 << FRAC_BITS;
  localparam int Z_MAX    = 6 << FRAC_BITS;

  // item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X    = 3'd0,
    REG_FOCAL_Y    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_NORMAL_X   = 3'd4,
    REG_NORMAL_Y   = 3'd5,
    REG_NORMAL_Z   = 3'd6,
    REG_PLANE_DIST = 3'd7
  } cfg_reg_t;

endpackage

@@ rtl/core/pixel_ray_plane_to_base.sv @@
// pixel to robot base-frame locator: ray back-projection, plane intersection, 3x4 transform
// throughput: one transaction per cycle unless the output stalls;
// two 34-stage divider pipelines in series set the depth
// a stalled output freezes the whole pipeline, the input stalls in the same cycle
// reset (rst, synchronous) clears all valid bits and loads the camera register defaults
// transform coefficients are undefined after reset until loaded
module pixel_ray_plane_to_base
  import prpb_pkg::*;
#(
  parameter int PIXEL_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [COEF_IDX_W-1:0]        coef_index,
  input  logic signed [RES_W-1:0]      coef_value,
  input  logic [PIXEL_BITS-1:0]        pixel_u,
  input  logic [PIXEL_BITS-1:0]        pixel_v,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [RES_W-1:0]      base_x,
  output logic signed [RES_W-1:0]      base_y,
  output logic [Z_W-1:0]               base_z,
  output logic                         ray_parallel
);

  localparam int NUM1_W = ((PIXEL_BITS + FRAC_BITS > FOCAL_W) ?
                           PIXEL_BITS + FRAC_BITS : FOCAL_W) + 1;
  localparam int DEN1_W = FOCAL_W + 1;
  localparam int PX_W   = RES_W + NORM_W;
  localparam int DEN2_W = PX_W + 2;
  localparam int DEN_W  = DEN2_W - FRAC_BITS;
  localparam int SUM_W  = TRUNC_W + 2;
  localparam int NPROD  = AXES * AXES;

  typedef struct packed {
    logic                    cmd;
    logic [COEF_IDX_W-1:0]   idx;
    logic signed [RES_W-1:0] val;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic signed [RES_W-1:0] rx;
    logic signed [RES_W-1:0] ry;
    logic                    par;
  } mid_t;

  // truncate a Q2F product toward zero back to QF
  function automatic logic signed [TRUNC_W-1:0] trunc_frac(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] b;
    b = v + (v[PROD_W-1] ? PROD_W'(FRAC_MASK) : PROD_W'(0));
    return b[PROD_W-1:FRAC_BITS];
  endfunction

  // saturate to signed 32 bits
  function automatic logic signed [RES_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-RES_W:0] hi;
    hi = v[SAT_IN_W-1:RES_W-1];
    if (&hi || ~|hi) begin
      return v[RES_W-1:0];
    end
    return v[SAT_IN_W-1] ? RES_MIN : RES_MAX;
  endfunction

  logic en;

  // camera registers
  logic [FOCAL_W-1:0]       focal_x, focal_y, center_x, center_y;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic signed [RES_W-1:0]  plane_dist;

  // transform coefficients
  logic signed [RES_W-1:0]  coef [0:COEF_DEPTH-1];

  // pipeline registers
  logic                     s0_valid, s1_valid;
  side_t                    s0_side, s1_side;
  logic [PIXEL_BITS-1:0]    s0_u, s0_v;
  logic signed [NUM1_W-1:0] s1_numx, s1_numy;
  logic signed [DEN1_W-1:0] s1_denx, s1_deny;

  logic                     v1_line  [0:DIV_LAT-1];
  side_t                    sd1_line [0:DIV_LAT-1];
  logic signed [RES_W-1:0]  rx, ry;

  logic                     a_valid, b_valid, c_valid, d_valid;
  side_t                    a_side, b_side, c_side;
  logic signed [RES_W-1:0]  a_rx, a_ry, b_rx, b_ry, c_rx, c_ry;
  logic signed [PX_W-1:0]   a_px, a_py;
  logic signed [DEN2_W-1:0] b_den2;
  logic signed [DEN_W-1:0]  c_den, d_den;
  mid_t                     d_mid;
  logic signed [TRUNC_W-1:0] c_trunc;

  logic                     v2_line  [0:DIV_LAT-1];
  mid_t                     md2_line [0:DIV_LAT-1];
  logic signed [RES_W-1:0]  t_quo;
  mid_t                     md2_out;

  logic                     e_valid, f_valid, g_valid;
  side_t                    e_side, f_side, g_side;
  logic                     e_par, f_par, g_par;
  logic signed [RES_W-1:0]  e_t, f_t;
  logic signed [PROD_W-1:0] e_mx, e_my;
  logic signed [TRUNC_W-1:0] f_tx, f_ty;
  logic signed [RES_W-1:0]  g_p [0:AXES-1];

  logic                     h_valid, i_valid, j_valid, k_valid, l_valid;
  logic                     h_par, i_par, j_par, k_par, l_par;
  logic signed [PROD_W-1:0] h_prod  [0:NPROD-1];
  logic signed [RES_W-1:0]  h_trans [0:AXES-1];
  logic signed [TRUNC_W-1:0] i_term [0:NPROD-1];
  logic signed [RES_W-1:0]  i_trans [0:AXES-1];
  logic signed [SUM_W-1:0]  j_sa [0:AXES-1];
  logic signed [SUM_W-1:0]  j_sb [0:AXES-1];
  logic signed [SUM_W-1:0]  k_acc [0:AXES-1];
  logic signed [RES_W-1:0]  l_b [0:AXES-1];

  logic signed [SAT_IN_W-1:0] x_off, z_off;

  // global advance: the whole pipeline holds while a result waits
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x    <= FOCAL_W'(FOCAL_RST);
      focal_y    <= FOCAL_W'(FOCAL_RST);
      center_x   <= FOCAL_W'(CX_RST);
      center_y   <= FOCAL_W'(CY_RST);
      normal_x   <= '0;
      normal_y   <= '0;
      normal_z   <= NORM_W'(NZ_RST);
      plane_dist <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_FOCAL_X:    focal_x    <= cfg_data[FOCAL_W-1:0];
        REG_FOCAL_Y:    focal_y    <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_X:   center_x   <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_Y:   center_y   <= cfg_data[FOCAL_W-1:0];
        REG_NORMAL_X:   normal_x   <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Y:   normal_y   <= cfg_data[NORM_W-1:0];
        REG_NORMAL_Z:   normal_z   <= cfg_data[NORM_W-1:0];
        REG_PLANE_DIST: plane_dist <= cfg_data[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) begin
        v1_line[k] <= 1'b0;
        v2_line[k] <= 1'b0;
      end
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      g_valid   <= 1'b0;
      h_valid   <= 1'b0;
      i_valid   <= 1'b0;
      j_valid   <= 1'b0;
      k_valid   <= 1'b0;
      l_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s0_valid   <= in_valid;
      s1_valid   <= s0_valid;
      v1_line[0] <= s1_valid;
      v2_line[0] <= d_valid;
      for (int k = 1; k < DIV_LAT; k++) begin
        v1_line[k] <= v1_line[k-1];
        v2_line[k] <= v2_line[k-1];
      end
      a_valid   <= v1_line[DIV_LAT-1];
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= v2_line[DIV_LAT-1];
      f_valid   <= e_valid;
      g_valid   <= f_valid;
      // loads end at the table, only locates go on
      h_valid   <= g_valid && (g_side.cmd == CMD_LOCATE);
      i_valid   <= h_valid;
      j_valid   <= i_valid;
      k_valid   <= j_valid;
      l_valid   <= k_valid;
      out_valid <= l_valid;
    end
  end

  // ray numerators and focal denominators
  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= '{cmd: cmd, idx: coef_index, val: coef_value};
      s0_u    <= pixel_u;
      s0_v    <= pixel_v;
      s1_side <= s0_side;
      s1_numx <= NUM1_W'({s0_u, {FRAC_BITS{1'b0}}}) - NUM1_W'(center_x);
      s1_numy <= NUM1_W'({s0_v, {FRAC_BITS{1'b0}}}) - NUM1_W'(center_y);
      s1_denx <= (focal_x == '0) ? DEN1_W'(1) : DEN1_W'(focal_x);
      s1_deny <= (focal_y == '0) ? DEN1_W'(1) : DEN1_W'(focal_y);
    end
  end

  // ray direction x and y
  prpb_div #(.NUM_W(NUM1_W), .DEN_W(DEN1_W)) u_div_rx (
    .clk (clk), .en (en), .num (s1_numx), .den (s1_denx), .quo (rx)
  );

  prpb_div #(.NUM_W(NUM1_W), .DEN_W(DEN1_W)) u_div_ry (
    .clk (clk), .en (en), .num (s1_numy), .den (s1_deny), .quo (ry)
  );

  // sideband delay lines beside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      sd1_line[0] <= s1_side;
      md2_line[0] <= d_mid;
      for (int k = 1; k < DIV_LAT; k++) begin
        sd1_line[k] <= sd1_line[k-1];
        md2_line[k] <= md2_line[k-1];
      end
    end
  end

  assign c_trunc = trunc_frac(PROD_W'(b_den2));
  assign md2_out = md2_line[DIV_LAT-1];

  // denominator d . n, truncated, and parallel test
  always_ff @(posedge clk) begin
    if (en) begin
      a_side <= sd1_line[DIV_LAT-1];
      a_rx   <= rx;
      a_ry   <= ry;
      a_px   <= PX_W'(rx) * PX_W'(normal_x);
      a_py   <= PX_W'(ry) * PX_W'(normal_y);
      b_side <= a_side;
      b_rx   <= a_rx;
      b_ry   <= a_ry;
      b_den2 <= DEN2_W'(a_px) + DEN2_W'(a_py) + (DEN2_W'(normal_z) <<< FRAC_BITS);
      c_side <= b_side;
      c_rx   <= b_rx;
      c_ry   <= b_ry;
      c_den  <= c_trunc[DEN_W-1:0];
      d_mid  <= '{side: c_side, rx: c_rx, ry: c_ry, par: (c_den == '0)};
      d_den  <= c_den;
    end
  end

  // distance along the ray
  prpb_div #(.NUM_W(RES_W), .DEN_W(DEN_W)) u_div_t (
    .clk (clk), .en (en), .num (plane_dist), .den (d_den), .quo (t_quo)
  );

  // camera point p = d * t
  always_ff @(posedge clk) begin
    if (en) begin
      e_side <= md2_out.side;
      e_par  <= md2_out.par;
      e_t    <= t_quo;
      e_mx   <= PROD_W'(md2_out.rx) * PROD_W'(t_quo);
      e_my   <= PROD_W'(md2_out.ry) * PROD_W'(t_quo);
      f_side <= e_side;
      f_par  <= e_par;
      f_t    <= e_t;
      f_tx   <= trunc_frac(e_mx);
      f_ty   <= trunc_frac(e_my);
      g_side <= f_side;
      g_par  <= f_par;
      g_p[0] <= f_par ? '0 : sat32(SAT_IN_W'(f_tx));
      g_p[1] <= f_par ? '0 : sat32(SAT_IN_W'(f_ty));
      g_p[2] <= f_par ? '0 : f_t;
    end
  end

  // coefficient loads take effect in pipeline order
  always_ff @(posedge clk) begin
    if (en && g_valid && (g_side.cmd == CMD_LOAD) && (g_side.idx < COEF_IDX_W'(COEF_DEPTH))) begin
      coef[g_side.idx] <= g_side.val;
    end
  end

  // transform rows: products, truncation, sums
  always_ff @(posedge clk) begin
    if (en) begin
      h_par <= g_par;
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          h_prod[r*AXES+c] <= PROD_W'(coef[r*COEF_COLS+c]) * PROD_W'(g_p[c]);
        end
        h_trans[r] <= coef[r*COEF_COLS+AXES];
      end
      i_par <= h_par;
      for (int m = 0; m < NPROD; m++) begin
        i_term[m] <= trunc_frac(h_prod[m]);
      end
      j_par <= i_par;
      k_par <= j_par;
      l_par <= k_par;
      for (int r = 0; r < AXES; r++) begin
        i_trans[r] <= h_trans[r];
        j_sa[r]    <= SUM_W'(i_term[r*AXES]) + SUM_W'(i_term[r*AXES+1]);
        j_sb[r]    <= SUM_W'(i_term[r*AXES+2]) + SUM_W'(i_trans[r]);
        k_acc[r]   <= j_sa[r] + j_sb[r];
        l_b[r]     <= sat32(SAT_IN_W'(k_acc[r]));
      end
    end
  end

  // base frame offsets and z clamp
  assign x_off = SAT_IN_W'(l_b[0]) + SAT_IN_W'(OFFSET_X);
  assign z_off = SAT_IN_W'(l_b[2]) - SAT_IN_W'(OFFSET_Z);

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      base_x       <= sat32(x_off);
      base_y       <= l_b[1];
      ray_parallel <= l_par;
      if (z_off < 0) begin
        base_z <= '0;
      end else if (z_off > SAT_IN_W'(Z_MAX)) begin
        base_z <= Z_W'(Z_MAX);
      end else begin
        base_z <= z_off[Z_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/prpb_div.sv @@
// pipelined restoring divider: num * 2^FRAC_BITS / den, truncated and saturated to 32 bits
module prpb_div
  import prpb_pkg::*;
#(
  parameter int NUM_W = 32,
  parameter int DEN_W = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic signed [RES_W-1:0] quo
);

  localparam int SHIFT_W = NUM_W + FRAC_BITS;
  localparam int HI_W    = SHIFT_W - QUO_BITS;
  localparam int CMP_W   = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [NUM_W-1:0]    n_mag;
  logic [DEN_W-1:0]    d_mag;
  logic [NUM_W-1:0]    n0;
  logic [DEN_W-1:0]    d0;
  logic                neg0;
  logic [SHIFT_W-1:0]  shifted;
  logic [CMP_W-1:0]    hi_ext;
  logic [CMP_W-1:0]    d_ext;

  logic [DEN_W-1:0]    rem_q [0:QUO_BITS];
  logic [DEN_W-1:0]    d_q   [0:QUO_BITS];
  logic [QUO_BITS-1:0] low_q [0:QUO_BITS];
  logic [QUO_BITS-1:0] q_q   [0:QUO_BITS];
  logic                neg_q [0:QUO_BITS];
  logic                ovf_q [0:QUO_BITS];

  // operand magnitudes
  assign n_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign d_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      n0   <= n_mag;
      d0   <= d_mag;
      neg0 <= num[NUM_W-1] ^ den[DEN_W-1];
    end
  end

  // overflow check on the top bits, seeds the partial remainder
  assign shifted = {n0, {FRAC_BITS{1'b0}}};
  assign hi_ext  = CMP_W'(shifted[SHIFT_W-1:QUO_BITS]);
  assign d_ext   = CMP_W'(d0);

  for (genvar k = 0; k <= QUO_BITS; k++) begin : g_step
    if (k == 0) begin : g_seed
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= hi_ext[DEN_W-1:0];
          d_q[k]   <= d0;
          low_q[k] <= shifted[QUO_BITS-1:0];
          q_q[k]   <= '0;
          neg_q[k] <= neg0;
          ovf_q[k] <= (hi_ext >= d_ext);
        end
      end
    end else begin : g_iter
      logic [DEN_W:0]   cur;
      logic [DEN_W+1:0] diff;

      // one quotient bit per stage
      assign cur  = {rem_q[k-1], low_q[k-1][QUO_BITS-k]};
      assign diff = {1'b0, cur} - {2'b00, d_q[k-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= diff[DEN_W+1] ? cur[DEN_W-1:0] : diff[DEN_W-1:0];
          d_q[k]   <= d_q[k-1];
          low_q[k] <= low_q[k-1];
          q_q[k]   <= {q_q[k-1][QUO_BITS-2:0], ~diff[DEN_W+1]};
          neg_q[k] <= neg_q[k-1];
          ovf_q[k] <= ovf_q[k-1];
        end
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_q[QUO_BITS]) begin
        quo <= neg_q[QUO_BITS] ? RES_MIN : RES_MAX;
      end else if (neg_q[QUO_BITS]) begin
        quo <= -RES_W'(q_q[QUO_BITS]);
      end else begin
        quo <= RES_W'(q_q[QUO_BITS]);
      end
    end
  end

endmodule

@@ rtl/core/prpb_chk.sv @@
// port-level checker for the pixel ray to base-frame locator, bound to the top level
module prpb_chk
  import prpb_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [RES_W-1:0] base_x,
  input logic [Z_W-1:0]          base_z
);

  // a waiting result holds its base_x value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(base_x))
    else $error("stalled result changed");

  // the input stalls exactly when the output is backed up
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // z stays within the clamp window
  a_z_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> base_z <= Z_W'(Z_MAX))
    else $error("base_z above clamp limit");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pixel_ray_plane_to_base prpb_chk u_prpb_chk (.*);
